FILE: design/vts_pkg.sv
// ---------------------------------------------------------------------------
// Voxel trilinear sampler package
// Shared constants, register indexes and the controller command bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vts_pkg;

  // Default geometry and number formats.
  localparam int GridSideDef     = 32;
  localparam int ValueBitsDef    = 16;
  localparam int FractionBitsDef = 8;

  // Port field widths.
  localparam int AddrFieldW  = 15;
  localparam int ValueFieldW = 16;
  localparam int PointW      = 16;
  localparam int SizeW       = 6;
  localparam int ThreshW     = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSizeX  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSizeY  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSizeZ  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegThresh = 2'd3;

  // Configuration reset values.
  localparam logic [SizeW-1:0]   SizeRst   = 6'd32;
  localparam logic [ThreshW-1:0] ThreshRst = 16'd66;

  // Item function codes.
  localparam logic FuncWrite  = 1'b0;
  localparam logic FuncSample = 1'b1;

  // Interpolation steps of the shared blend unit.
  localparam logic [2:0] StepB0 = 3'd0;
  localparam logic [2:0] StepB1 = 3'd1;
  localparam logic [2:0] StepY0 = 3'd2;
  localparam logic [2:0] StepC0 = 3'd3;
  localparam logic [2:0] StepC1 = 3'd4;
  localparam logic [2:0] StepY1 = 3'd5;
  localparam logic [2:0] StepZ  = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;    // write the voxel on the ports into the store
    logic       load;     // take a query point from the ports
    logic       rd_en;    // issue a store read for one corner
    logic [2:0] rd_sel;   // corner being read
    logic       cap_en;   // capture the registered read data
    logic [2:0] cap_sel;  // corner being captured
    logic       mul_en;   // blend unit, product stage
    logic       add_en;   // blend unit, sum stage
    logic [2:0] step;     // blend step in progress
  } vts_cmd_t;

endpackage

FILE: design/vts_ctrl.sv
// ---------------------------------------------------------------------------
// Voxel trilinear sampler controller
// Sequences the eight corner reads and the seven blend steps of a query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              func_i,
  output logic              busy_o,
  output logic              valid_o,
  output vts_pkg::vts_cmd_t cmd_o
);
  import vts_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StAdd  = 2'd3;

  localparam logic [3:0] ReadLast = 4'd8;

  logic [1:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] step_q, step_d;
  logic       valid_q, valid_d;
  logic       accept;

  assign accept  = start_i && (state_q == StIdle);
  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;

  // Commands decoded from the current state and, for writes and loads, from start.
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_en   = accept && (func_i == FuncWrite);
    cmd_o.load    = accept && (func_i == FuncSample);
    cmd_o.rd_en   = (state_q == StRead) && !cnt_q[3];
    cmd_o.rd_sel  = cnt_q[2:0];
    cmd_o.cap_en  = (state_q == StRead) && (cnt_q != 4'd0);
    cmd_o.cap_sel = 3'(cnt_q - 4'd1);
    cmd_o.mul_en  = (state_q == StMul);
    cmd_o.add_en  = (state_q == StAdd);
    cmd_o.step    = step_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StRead;
          cnt_d   = 4'd0;
        end
      end
      StRead: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == ReadLast) begin
          state_d = StMul;
          step_d  = StepB0;
        end
      end
      StMul: begin
        state_d = StAdd;
      end
      StAdd: begin
        if (step_q == StepZ) begin
          state_d = StIdle;
          valid_d = 1'b1;
        end else begin
          state_d = StMul;
          step_d  = step_q + 3'd1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= 4'd0;
      step_q  <= StepB0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: design/vts_datapath.sv
// ---------------------------------------------------------------------------
// Voxel trilinear sampler datapath
// Voxel store, corner addressing, neighbourhood maximum and the blend unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vts_datapath #(
  parameter int GRID_SIDE     = vts_pkg::GridSideDef,
  parameter int VALUE_BITS    = vts_pkg::ValueBitsDef,
  parameter int FRACTION_BITS = vts_pkg::FractionBitsDef
) (
  input  logic                             clk_i,
  input  vts_pkg::vts_cmd_t                cmd_i,
  input  logic [vts_pkg::AddrFieldW-1:0]   voxel_address_i,
  input  logic [vts_pkg::ValueFieldW-1:0]  voxel_value_i,
  input  logic signed [vts_pkg::PointW-1:0] point_x_i,
  input  logic signed [vts_pkg::PointW-1:0] point_y_i,
  input  logic signed [vts_pkg::PointW-1:0] point_z_i,
  input  logic [vts_pkg::SizeW-1:0]        size_x_i,
  input  logic [vts_pkg::SizeW-1:0]        size_y_i,
  input  logic [vts_pkg::SizeW-1:0]        size_z_i,
  input  logic [vts_pkg::ThreshW-1:0]      low_threshold_i,
  output logic [vts_pkg::ValueFieldW-1:0]  density_o
);
  import vts_pkg::*;

  localparam int Depth   = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AddrW   = $clog2(Depth);
  localparam int IdxW    = $clog2(GRID_SIDE);
  localparam int VB      = VALUE_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int HalfFix = 2 ** (FRACTION_BITS - 1);
  localparam int CmpW    = (VALUE_BITS > ThreshW) ? VALUE_BITS : ThreshW;
  localparam int ProdW   = VALUE_BITS + FRACTION_BITS + 2;
  localparam int SumW    = VALUE_BITS + FRACTION_BITS + 3;

  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    logic [F-1:0]    frac;
  } axis_t;

  // Centre cell as floor(p + 0.5), the two cells clamped to the size in use.
  function automatic axis_t split_axis(input logic signed [PointW-1:0] p,
                                       input logic [SizeW-1:0] size);
    logic signed [PointW:0]   t;
    logic signed [PointW+1:0] c;
    logic signed [PointW+1:0] cm1;
    logic signed [PointW+1:0] lim;
    logic [SizeW:0]           eff;
    axis_t                    r;
    t = {p[PointW-1], p} + (PointW+1)'(HalfFix);
    c = (PointW+2)'(t);
    c = c >>> F;
    cm1 = c - (PointW+2)'(1);
    if (size == '0) begin
      eff = (SizeW+1)'(1);
    end else if ((SizeW+1)'(size) > (SizeW+1)'(GRID_SIDE)) begin
      eff = (SizeW+1)'(GRID_SIDE);
    end else begin
      eff = (SizeW+1)'(size);
    end
    lim = (PointW+2)'(eff);
    lim = lim - (PointW+2)'(1);
    if (cm1 < 0) begin
      r.lo = '0;
    end else if (cm1 > lim) begin
      r.lo = lim[IdxW-1:0];
    end else begin
      r.lo = cm1[IdxW-1:0];
    end
    if (c < 0) begin
      r.hi = '0;
    end else if (c > lim) begin
      r.hi = lim[IdxW-1:0];
    end else begin
      r.hi = c[IdxW-1:0];
    end
    r.frac = t[F-1:0];
    return r;
  endfunction

  // Densities below the threshold take the neighbourhood maximum.
  function automatic logic [VB-1:0] subst(input logic [VB-1:0] v,
                                          input logic [VB-1:0] vmax,
                                          input logic [ThreshW-1:0] thr);
    if (CmpW'(v) < CmpW'(thr)) begin
      return vmax;
    end
    return v;
  endfunction

  logic [VB-1:0]    mem [Depth];
  axis_t            ax_q, ay_q, az_q;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             wr_in_range;
  logic [IdxW-1:0]  cx, cy, cz;
  logic [VB-1:0]    rd_data_q;
  logic [VB-1:0]    v_q [8];
  logic [VB-1:0]    vmax_q;
  logic [VB-1:0]    b0_q, b1_q, y0_q, c0_q, c1_q, y1_q;
  logic [VB-1:0]    density_q;
  logic [VB-1:0]    op_a, op_b;
  logic [F-1:0]     op_r;
  logic signed [VB:0]      diff;
  logic signed [F:0]       weight;
  logic signed [ProdW-1:0] prod_q;
  logic [VB-1:0]           a_q;
  logic signed [SumW-1:0]  sum;
  logic [VB-1:0]           blend;

  // Query point: split each axis at the transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= split_axis(point_x_i, size_x_i);
      ay_q <= split_axis(point_y_i, size_y_i);
      az_q <= split_axis(point_z_i, size_z_i);
    end
  end

  // Write address, dropped when it lies beyond the store.
  assign wr_in_range = ({{(32-AddrFieldW){1'b0}}, voxel_address_i} < 32'(Depth));
  assign wr_addr     = AddrW'(voxel_address_i);

  // Corner order: x high on corners 1, 2, 5, 6; y high on 2, 3, 6, 7; z high on 4 to 7.
  assign cx = (cmd_i.rd_sel[0] ^ cmd_i.rd_sel[1]) ? ax_q.hi : ax_q.lo;
  assign cy = cmd_i.rd_sel[1] ? ay_q.hi : ay_q.lo;
  assign cz = cmd_i.rd_sel[2] ? az_q.hi : az_q.lo;
  assign rd_addr = AddrW'(cx) + AddrW'(cy) * AddrW'(GRID_SIDE)
                 + AddrW'(cz) * AddrW'(GRID_SIDE * GRID_SIDE);

  // Voxel store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_in_range) begin
      mem[wr_addr] <= VB'(voxel_value_i);
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Corner capture and running maximum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vmax_q <= '0;
    end else if (cmd_i.cap_en) begin
      v_q[cmd_i.cap_sel] <= rd_data_q;
      if (rd_data_q > vmax_q) begin
        vmax_q <= rd_data_q;
      end
    end
  end

  // Operand selection for each blend step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_r = ax_q.frac;
    unique case (cmd_i.step)
      StepB0: begin
        op_a = subst(v_q[0], vmax_q, low_threshold_i);
        op_b = subst(v_q[1], vmax_q, low_threshold_i);
      end
      StepB1: begin
        op_a = subst(v_q[3], vmax_q, low_threshold_i);
        op_b = subst(v_q[2], vmax_q, low_threshold_i);
      end
      StepY0: begin
        op_a = b0_q;
        op_b = b1_q;
        op_r = ay_q.frac;
      end
      StepC0: begin
        op_a = subst(v_q[4], vmax_q, low_threshold_i);
        op_b = subst(v_q[5], vmax_q, low_threshold_i);
      end
      StepC1: begin
        op_a = subst(v_q[7], vmax_q, low_threshold_i);
        op_b = subst(v_q[6], vmax_q, low_threshold_i);
      end
      StepY1: begin
        op_a = c0_q;
        op_b = c1_q;
        op_r = ay_q.frac;
      end
      StepZ: begin
        op_a = y0_q;
        op_b = y1_q;
        op_r = az_q.frac;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Blend unit, product stage: a*(1 - r) + b*r is formed as a*2^F + (b - a)*r.
  assign diff   = $signed({1'b0, op_b}) - $signed({1'b0, op_a});
  assign weight = $signed({1'b0, op_r});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= diff * weight;
      a_q    <= op_a;
    end
  end

  // Blend unit, sum stage with rounding.
  assign sum   = $signed({3'b000, a_q, {F{1'b0}}}) + SumW'(prod_q) + SumW'(HalfFix);
  assign blend = sum[F +: VB];

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      unique case (cmd_i.step)
        StepB0:  b0_q      <= blend;
        StepB1:  b1_q      <= blend;
        StepY0:  y0_q      <= blend;
        StepC0:  c0_q      <= blend;
        StepC1:  c1_q      <= blend;
        StepY1:  y1_q      <= blend;
        StepZ:   density_q <= blend;
        default: density_q <= density_q;
      endcase
    end
  end

  assign density_o = ValueFieldW'(density_q);

endmodule

FILE: design/voxel_trilinear_sampler.sv
// ---------------------------------------------------------------------------
// Voxel trilinear sampler
// Holds a density volume and returns trilinearly blended samples of it.
// ---------------------------------------------------------------------------
// A voxel write is stored at the start edge; busy stays low and another item
// may follow. A sample takes its point at the start edge; the eight corner
// reads go one by one through the single store read port, then seven blend
// steps, each a product and a sum stage on the shared unit, precede valid_o.
// busy falls as valid_o rises; until then a new start is not taken.
// Reset clears the control state and the configuration registers, not the store or the datapath registers.
`timescale 1ns / 1ps

module voxel_trilinear_sampler #(
  parameter int GRID_SIDE     = vts_pkg::GridSideDef,
  parameter int VALUE_BITS    = vts_pkg::ValueBitsDef,
  parameter int FRACTION_BITS = vts_pkg::FractionBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [vts_pkg::AddrFieldW-1:0]    voxel_address_i,
  input  logic [vts_pkg::ValueFieldW-1:0]   voxel_value_i,
  input  logic signed [vts_pkg::PointW-1:0] point_x_i,
  input  logic signed [vts_pkg::PointW-1:0] point_y_i,
  input  logic signed [vts_pkg::PointW-1:0] point_z_i,
  output logic                              valid_o,
  output logic [vts_pkg::ValueFieldW-1:0]   density_o,
  input  logic                              cfg_we_i,
  input  logic [vts_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [vts_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import vts_pkg::*;

  logic [SizeW-1:0]   size_x_q, size_y_q, size_z_q;
  logic [ThreshW-1:0] low_threshold_q;
  vts_cmd_t           cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q        <= SizeRst;
      size_y_q        <= SizeRst;
      size_z_q        <= SizeRst;
      low_threshold_q <= ThreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSizeX:  size_x_q        <= cfg_wdata_i[SizeW-1:0];
        RegSizeY:  size_y_q        <= cfg_wdata_i[SizeW-1:0];
        RegSizeZ:  size_z_q        <= cfg_wdata_i[SizeW-1:0];
        RegThresh: low_threshold_q <= cfg_wdata_i[ThreshW-1:0];
        default:   low_threshold_q <= low_threshold_q;
      endcase
    end
  end

  vts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .busy_o  (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  vts_datapath #(
    .GRID_SIDE     (GRID_SIDE),
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .voxel_address_i (voxel_address_i),
    .voxel_value_i   (voxel_value_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .size_x_i        (size_x_q),
    .size_y_i        (size_y_q),
    .size_z_i        (size_z_q),
    .low_threshold_i (low_threshold_q),
    .density_o       (density_o)
  );

endmodule
